/* rtl/fxalu_pkg.sv */
// shared types, action codes and constants for the fixed-point alu
`default_nettype none
package fxalu_pkg;
	localparam int FRAC_BITS_DEF = 8;

	typedef enum logic [3:0] {
		ACT_ADD = 4'd0, ACT_SUB = 4'd1, ACT_MUL = 4'd2, ACT_DIV = 4'd3,
		ACT_LT = 4'd4, ACT_GT = 4'd5, ACT_LE = 4'd6, ACT_GE = 4'd7,
		ACT_EQ = 4'd8, ACT_NE = 4'd9, ACT_MIN = 4'd10, ACT_MAX = 4'd11,
		ACT_INC = 4'd12, ACT_DEC = 4'd13, ACT_R14 = 4'd14, ACT_R15 = 4'd15
	} action_t;

	typedef struct packed {
		action_t            action;
		logic signed [31:0] operand_a;
		logic signed [31:0] operand_b;
	} item_in_t;

	typedef struct packed {
		logic signed [31:0] result_value;
		logic               compare_true;
		logic               div_zero;
		logic               overflow;
	} item_out_t;

	// saturate an unsigned magnitude with a sign to 32 bits
	function automatic logic [32:0] sat_signed(input logic [63:0] mag, input logic neg);
		logic [32:0] r;
		r = '0;
		if (neg) begin
			if (mag > 64'h8000_0000) r = {1'b1, 32'h8000_0000};
			else r = {1'b0, 32'(~mag[31:0] + 32'd1)};
		end else begin
			if (mag > 64'h7FFF_FFFF) r = {1'b1, 32'h7FFF_FFFF};
			else r = {1'b0, mag[31:0]};
		end
		return r;
	endfunction
endpackage
`default_nettype wire

/* rtl/fxalu_mul.sv */
// pipelined magnitude multiplier built from four 16x16 partial products
`default_nettype none
module fxalu_mul (
	input  wire logic        clk,
	input  wire logic [31:0] a,
	input  wire logic [31:0] b,
	output logic      [63:0] p
);
	logic [31:0] ll_s1, lh_s1, hl_s1, hh_s1;
	logic [63:0] sum_s2, p_s3;

	always_ff @(posedge clk) begin
		ll_s1  <= a[15:0] * b[15:0];
		lh_s1  <= a[15:0] * b[31:16];
		hl_s1  <= a[31:16] * b[15:0];
		hh_s1  <= a[31:16] * b[31:16];
		sum_s2 <= {hh_s1, ll_s1} + {15'd0, {1'b0, lh_s1} + {1'b0, hl_s1}, 16'd0};
		p_s3   <= sum_s2;
	end
	assign p = p_s3;
endmodule
`default_nettype wire

/* rtl/fxalu_div.sv */
// restoring divider pipeline, one quotient bit per stage
`default_nettype none
module fxalu_div #(
	parameter int NUM_BITS = 48
) (
	input  wire logic                clk,
	input  wire logic [NUM_BITS-1:0] num,
	input  wire logic [31:0]         den,
	output logic      [NUM_BITS-1:0] quo
);
	logic [NUM_BITS-1:0] q_s [NUM_BITS+1];
	logic [32:0]         r_s [NUM_BITS];
	logic [31:0]         d_s [NUM_BITS];

	assign q_s[0] = num;
	assign r_s[0] = '0;
	assign d_s[0] = den;

	for (genvar i = 0; i < NUM_BITS; i++) begin : g_st
		logic [33:0] t;
		logic        ge;
		assign t  = {r_s[i], q_s[i][NUM_BITS-1]};
		assign ge = t >= {2'b00, d_s[i]};
		always_ff @(posedge clk) begin
			q_s[i+1] <= {q_s[i][NUM_BITS-2:0], ge};
		end
		// the last stage only hands on its quotient
		if (i < NUM_BITS - 1) begin : g_rd
			always_ff @(posedge clk) begin
				r_s[i+1] <= ge ? 33'(t - {2'b00, d_s[i]}) : t[32:0];
				d_s[i+1] <= d_s[i];
			end
		end
	end
	assign quo = q_s[NUM_BITS];
endmodule
`default_nettype wire

/* rtl/fixed_point_alu.sv */
// top level of the pipelined fixed-point alu
// usage: drive item and pulse start while busy is low; busy is always low,
// so one item may enter every cycle. each item yields exactly one result
// on result with done high for one cycle.
// from start to done an item passes the input register, the restoring
// divider (one quotient bit per stage) and the output register; all
// actions take this same path, so results leave in order. throughput
// is one item per cycle.
// multiply goes through a three-stage 16x16 partial product array.
// reset clears the valid bits; items in flight are dropped.
// the receiver cannot stall, so nothing holds the pipeline.
`default_nettype none
module fixed_point_alu #(
	parameter int FRAC_BITS = fxalu_pkg::FRAC_BITS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	output logic                      busy,
	input  wire fxalu_pkg::item_in_t  item,
	output logic                      done,
	output fxalu_pkg::item_out_t      result
);
	localparam int NB  = 32 + FRAC_BITS;
	localparam int LAT = NB + 1;

	logic signed [31:0] a, b;
	logic        neg, lt;
	logic [31:0] ma, mb;
	fxalu_pkg::item_out_t simple;
	assign a   = item.operand_a;
	assign b   = item.operand_b;
	assign neg = a[31] ^ b[31];
	assign lt  = a < b;
	assign ma  = a[31] ? 32'(-a) : a;
	assign mb  = b[31] ? 32'(-b) : b;
	assign busy = 1'b0;

	always_comb begin
		simple = '0;
		case (item.action)
			fxalu_pkg::ACT_ADD: simple.result_value = a + b;
			fxalu_pkg::ACT_SUB: simple.result_value = a - b;
			fxalu_pkg::ACT_LT:  simple.compare_true = lt;
			fxalu_pkg::ACT_GT:  simple.compare_true = a > b;
			fxalu_pkg::ACT_LE:  simple.compare_true = a <= b;
			fxalu_pkg::ACT_GE:  simple.compare_true = a >= b;
			fxalu_pkg::ACT_EQ:  simple.compare_true = a == b;
			fxalu_pkg::ACT_NE:  simple.compare_true = a != b;
			fxalu_pkg::ACT_MIN: simple.result_value = lt ? a : b;
			fxalu_pkg::ACT_MAX: simple.result_value = lt ? b : a;
			fxalu_pkg::ACT_INC: simple.result_value = a + (32'sd1 <<< FRAC_BITS);
			fxalu_pkg::ACT_DEC: simple.result_value = a - (32'sd1 <<< FRAC_BITS);
			default:            simple = '0;
		endcase
	end

	// input register feeding both arithmetic units
	logic [31:0] ma_s1, mb_s1;
	logic        v_s1, neg_s1, dz_s1;
	fxalu_pkg::action_t act_s1;
	fxalu_pkg::item_out_t simple_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else v_s1 <= start;
	end
	always_ff @(posedge clk) begin
		ma_s1 <= ma; mb_s1 <= mb; neg_s1 <= neg; dz_s1 <= (b == 32'sd0);
		act_s1 <= item.action; simple_s1 <= simple;
	end

	logic [63:0] prod;
	logic [NB-1:0] quo;
	fxalu_mul u_mul (.clk(clk), .a(ma_s1), .b(mb_s1), .p(prod));
	fxalu_div #(.NUM_BITS(NB)) u_div (.clk(clk), .num({ma_s1, FRAC_BITS'(0)}),
		.den(mb_s1), .quo(quo));

	// side info line matched to divider depth
	typedef struct packed {
		logic v; logic neg; logic dz; fxalu_pkg::action_t act; fxalu_pkg::item_out_t s;
	} side_t;
	side_t side_s [LAT];
	assign side_s[0] = '{v: v_s1, neg: neg_s1, dz: dz_s1, act: act_s1, s: simple_s1};
	for (genvar i = 1; i < LAT; i++) begin : g_side
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) side_s[i] <= '0;
			else side_s[i] <= side_s[i-1];
		end
	end

	// multiply result waits for the divider
	logic [63:0] prod_s [NB-2];
	assign prod_s[0] = prod;
	for (genvar i = 0; i < NB - 3; i++) begin : g_pd
		always_ff @(posedge clk) prod_s[i+1] <= prod_s[i];
	end

	localparam int SL = LAT - 1;
	logic [32:0] msat, dsat;
	logic [63:0] pshift;
	assign pshift = prod_s[NB-3] >> FRAC_BITS;
	assign msat = fxalu_pkg::sat_signed(pshift, side_s[SL].neg);
	assign dsat = fxalu_pkg::sat_signed(64'(quo), side_s[SL].neg);

	logic        v_out_s;
	fxalu_pkg::item_out_t out_s;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_out_s <= 1'b0;
		else v_out_s <= side_s[SL].v;
	end
	always_ff @(posedge clk) begin
		if (side_s[SL].act == fxalu_pkg::ACT_MUL) begin
			out_s <= '{result_value: msat[31:0], compare_true: 1'b0, div_zero: 1'b0,
				overflow: msat[32]};
		end else if (side_s[SL].act == fxalu_pkg::ACT_DIV && side_s[SL].dz) begin
			out_s <= '{result_value: 32'sd0, compare_true: 1'b0,
				div_zero: 1'b1, overflow: 1'b0};
		end else if (side_s[SL].act == fxalu_pkg::ACT_DIV) begin
			out_s <= '{result_value: dsat[31:0], compare_true: 1'b0, div_zero: 1'b0,
				overflow: dsat[32]};
		end else begin
			out_s <= side_s[SL].s;
		end
	end
	assign done   = v_out_s;
	assign result = out_s;

`ifndef SYNTHESIS
	a_zero_flags: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(result.div_zero && result.overflow)) else $error("dz with ovf");
	a_cmp_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.compare_true |-> result.result_value == 32'sd0)
		else $error("compare with value");
	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |-> ##(LAT) done) else $error("latency");
`endif
endmodule
`default_nettype wire
